>>> src/deq_pkg.sv
package deq_pkg;

  localparam int DATA_W        = 32;
  localparam int KIND_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int POS_W         = 6;   // covers every cell index up to the largest depth
  localparam int DEPTH_DEFAULT = 32;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_PUSH_HEAD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_TAIL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ_HEAD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_TAIL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic                     last;
  } out_res_t;

  // cell operations
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHR   = 2'd1,  // cell 0 takes wrap, others take left neighbour
    CELL_SHL   = 2'd2,  // cell at pos takes wrap, others take right neighbour
    CELL_LOAD  = 2'd3   // cell at pos takes wrap, others hold
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [POS_W-1:0]   pos;
  } cell_ctl_t;

endpackage

>>> src/deq_cell.sv
module deq_cell #(
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  deq_pkg::cell_ctl_t                ctl,
  input  logic signed [deq_pkg::DATA_W-1:0] left_i,
  input  logic signed [deq_pkg::DATA_W-1:0] right_i,
  input  logic signed [deq_pkg::DATA_W-1:0] wrap_i,
  output logic signed [deq_pkg::DATA_W-1:0] q_o
);

  logic signed [deq_pkg::DATA_W-1:0] data_r;
  logic signed [deq_pkg::DATA_W-1:0] data_nxt;
  logic                              at_pos;

  assign at_pos = (ctl.pos == deq_pkg::POS_W'(IDX));

  always_comb begin
    unique case (ctl.op)
      deq_pkg::CELL_HOLD: data_nxt = data_r;
      deq_pkg::CELL_SHR:  data_nxt = (IDX == 0) ? wrap_i : left_i;
      deq_pkg::CELL_SHL:  data_nxt = at_pos ? wrap_i : right_i;
      deq_pkg::CELL_LOAD: data_nxt = at_pos ? wrap_i : data_r;
      default:            data_nxt = data_r;
    endcase
  end

  // payload only: no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q_o = data_r;

endmodule

>>> src/deque_with_remove_all_max.sv
// Bounded double-ended queue of signed values held in a row of DEPTH cells,
// head in cell 0, entries packed towards the head.
// Input channel: present a request on in_req with start high; it is taken at
// the edge where start is high and busy is low. Kinds: push at head, push at
// tail, read out from head, read out from tail, remove every maximum entry.
// Result channel: each result sits on out_res for one cycle with out_valid
// high; the receiver cannot stall it, so results are never held back.
// Timing: a push (or a read-out or removal on an empty store) gives its
// single result in the cycle after acceptance and busy stays low, so pushes are
// taken one per cycle. A read-out of n entries keeps busy high until all n
// are out and gives one result per cycle, the first passing through the state
// and result registers. A removal rotates the cell row twice (scan for the
// maximum, then compaction) and stays busy for both, its result registered
// after the last compaction step. The row moves one entry past cell 0 per cycle.
// Reset: the queue becomes empty and no result is pending; cell contents are
// left as they are and are never read before being written.
module deque_with_remove_all_max #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  deq_pkg::in_req_t  in_req,
  output logic              out_valid,
  output deq_pkg::out_res_t out_res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_PACK = 4'b1000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [CW-1:0]                     step_r, step_nxt;
  logic [CW-1:0]                     total_r, total_nxt;
  logic                              tail_r, tail_nxt;
  logic signed [deq_pkg::DATA_W-1:0] max_r, max_nxt;
  logic                              out_valid_r, out_valid_nxt;
  deq_pkg::out_res_t                 out_res_r, out_res_nxt;

  deq_pkg::cell_ctl_t                ctl;
  logic signed [deq_pkg::DATA_W-1:0] wrap;
  logic signed [deq_pkg::DATA_W-1:0] cell_q [DEPTH];
  logic signed [deq_pkg::DATA_W-1:0] head_q;
  logic signed [deq_pkg::DATA_W-1:0] tail_q;
  logic [CW-1:0]                     count_m1;
  logic                              full;
  logic                              accept;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign count_m1 = count_r - CW'(1);
  assign full     = (count_r == CW'(DEPTH));
  assign head_q   = cell_q[0];
  assign tail_q   = cell_q[count_m1[IW-1:0]];

  // cell row: each cell sees its neighbours and the shared wrap value
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    deq_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .left_i  ((g == 0) ? wrap : cell_q[(g == 0) ? 0 : g - 1]),
      .right_i ((g == DEPTH - 1) ? wrap : cell_q[(g == DEPTH - 1) ? g : g + 1]),
      .wrap_i  (wrap),
      .q_o     (cell_q[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    total_nxt     = total_r;
    tail_nxt      = tail_r;
    max_nxt       = max_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    ctl.op        = deq_pkg::CELL_HOLD;
    ctl.pos       = deq_pkg::POS_W'(count_m1);
    wrap          = head_q;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_res_nxt.data = '0;
          out_res_nxt.last = 1'b1;
          unique case (in_req.kind)
            deq_pkg::KIND_PUSH_HEAD, deq_pkg::KIND_PUSH_TAIL: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_res_nxt.status = deq_pkg::ST_FULL;
              end else begin
                // push at head shifts the row right; push at tail loads cell n
                out_res_nxt.status = deq_pkg::ST_OK;
                wrap               = in_req.value;
                ctl.pos            = deq_pkg::POS_W'(count_r);
                ctl.op             = (in_req.kind == deq_pkg::KIND_PUSH_HEAD) ?
                                     deq_pkg::CELL_SHR : deq_pkg::CELL_LOAD;
                count_nxt          = count_r + CW'(1);
              end
            end
            deq_pkg::KIND_READ_HEAD, deq_pkg::KIND_READ_TAIL,
            deq_pkg::KIND_REMOVE: begin
              if (count_r == '0) begin
                out_valid_nxt      = 1'b1;
                out_res_nxt.status = deq_pkg::ST_EMPTY;
              end else begin
                step_nxt = '0;
                tail_nxt = (in_req.kind == deq_pkg::KIND_READ_TAIL);
                max_nxt  = head_q;
                state_nxt = (in_req.kind == deq_pkg::KIND_REMOVE) ? S_SCAN : S_READ;
              end
            end
            default: begin
              // unknown kinds: drop silently
            end
          endcase
        end
      end

      S_READ: begin
        // emit one entry a cycle and rotate it to the other end
        out_valid_nxt      = 1'b1;
        out_res_nxt.status = deq_pkg::ST_OK;
        out_res_nxt.last   = (step_r == count_m1);
        if (tail_r) begin
          out_res_nxt.data = tail_q;
          wrap             = tail_q;
          ctl.op           = deq_pkg::CELL_SHR;
        end else begin
          out_res_nxt.data = head_q;
          ctl.op           = deq_pkg::CELL_SHL;
        end
        step_nxt = step_r + CW'(1);
        if (step_r == count_m1) begin
          state_nxt = S_IDLE;
        end
      end

      S_SCAN: begin
        // one full rotation: the row ends in its original order
        ctl.op = deq_pkg::CELL_SHL;
        if (head_q > max_r) begin
          max_nxt = head_q;
        end
        step_nxt = step_r + CW'(1);
        if (step_r == count_m1) begin
          step_nxt  = '0;
          total_nxt = count_r;
          state_nxt = S_PACK;
        end
      end

      S_PACK: begin
        // rotate kept entries to the back, drop maximum ones by shrinking
        ctl.op = deq_pkg::CELL_SHL;
        if (head_q == max_r) begin
          count_nxt = count_m1;
        end
        step_nxt = step_r + CW'(1);
        if (step_r == total_r - CW'(1)) begin
          state_nxt          = S_IDLE;
          out_valid_nxt      = 1'b1;
          out_res_nxt.data   = max_r;
          out_res_nxt.status = deq_pkg::ST_REMOVED;
          out_res_nxt.last   = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold working values and the result payload without reset
  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    total_r   <= total_nxt;
    tail_r    <= tail_nxt;
    max_r     <= max_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (count_r != '0))
    else $error("busy with an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_push_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.kind == deq_pkg::KIND_PUSH_HEAD ||
                in_req.kind == deq_pkg::KIND_PUSH_TAIL)) |=> out_valid)
    else $error("push request not acknowledged");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.last) |-> !busy)
    else $error("final result while still busy");

endmodule

>>> tb/deq_result_checker.sv
`timescale 1ns / 100ps

// Watch both channels of the deque, keep a shadow copy of its contents and
// compare every result against the oldest one still awaited.
module deq_result_checker #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  deq_pkg::in_req_t  in_req,
  input  logic              out_valid,
  input  deq_pkg::out_res_t out_res,
  output int                mismatch_count,
  output int                outstanding
);

  logic signed [deq_pkg::DATA_W-1:0] shadow_q[$];   // head at index 0
  deq_pkg::out_res_t                 awaited_q[$];
  int                                fail_cnt    = 0;
  int                                pending_cnt = 0;

  assign mismatch_count = fail_cnt;
  assign outstanding    = pending_cnt;

  function automatic deq_pkg::out_res_t make_res(logic signed [deq_pkg::DATA_W-1:0] d,
                                                 logic [deq_pkg::STATUS_W-1:0] s,
                                                 logic l);
    deq_pkg::out_res_t r;
    r.data   = d;
    r.status = s;
    r.last   = l;
    return r;
  endfunction

  // queue one awaited result behind the others
  task automatic await_res(deq_pkg::out_res_t r);
    awaited_q.insert(awaited_q.size(), r);
  endtask

  task automatic apply_request(deq_pkg::in_req_t req);
    logic signed [deq_pkg::DATA_W-1:0] peak;
    logic signed [deq_pkg::DATA_W-1:0] kept_q[$];
    int                                i;
    case (req.kind)
      deq_pkg::KIND_PUSH_HEAD, deq_pkg::KIND_PUSH_TAIL: begin
        if (shadow_q.size() >= DEPTH) begin
          await_res(make_res('0, deq_pkg::ST_FULL, 1'b1));
        end else begin
          if (req.kind == deq_pkg::KIND_PUSH_HEAD) shadow_q.insert(0, req.value);
          else shadow_q.insert(shadow_q.size(), req.value);
          await_res(make_res('0, deq_pkg::ST_OK, 1'b1));
        end
      end
      deq_pkg::KIND_READ_HEAD, deq_pkg::KIND_READ_TAIL, deq_pkg::KIND_REMOVE: begin
        if (shadow_q.size() == 0) begin
          await_res(make_res('0, deq_pkg::ST_EMPTY, 1'b1));
        end else if (req.kind == deq_pkg::KIND_READ_HEAD) begin
          for (i = 0; i < shadow_q.size(); i++)
            await_res(make_res(shadow_q[i], deq_pkg::ST_OK, i == shadow_q.size() - 1));
        end else if (req.kind == deq_pkg::KIND_READ_TAIL) begin
          for (i = shadow_q.size() - 1; i >= 0; i--)
            await_res(make_res(shadow_q[i], deq_pkg::ST_OK, i == 0));
        end else begin
          // maximum starts at the head; signed compare
          peak = shadow_q[0];
          for (i = 1; i < shadow_q.size(); i++)
            if (shadow_q[i] > peak) peak = shadow_q[i];
          for (i = 0; i < shadow_q.size(); i++)
            if (shadow_q[i] != peak) kept_q.insert(kept_q.size(), shadow_q[i]);
          shadow_q = kept_q;
          await_res(make_res(peak, deq_pkg::ST_REMOVED, 1'b1));
        end
      end
      default: ;  // unused kinds: drop silently
    endcase
  endtask

  task automatic note_failure(string what, deq_pkg::out_res_t want);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("%0t: %s: expected data %0d status %0d last %0b, %s %0d status %0d last %0b",
               $realtime, what, want.data, want.status, want.last, "got data",
               out_res.data, out_res.status, out_res.last);
  endtask

  always @(posedge clk) begin : watch
    deq_pkg::out_res_t want;
    if (rst_n) begin
      // results of earlier requests first, then the request taken at this edge
      if (out_valid) begin
        if (awaited_q.size() == 0) begin
          note_failure("unexpected result", make_res('0, deq_pkg::ST_OK, 1'b0));
        end else begin
          want = awaited_q.pop_front();
          if (out_res.data !== want.data || out_res.status !== want.status ||
              out_res.last !== want.last)
            note_failure("result mismatch", want);
        end
      end
      if (start && !busy) apply_request(in_req);
    end
    pending_cnt = awaited_q.size();
  end

endmodule

>>> tb/tb_deque_with_remove_all_max.sv
`timescale 1ns / 100ps

module tb_deque_with_remove_all_max;

  localparam int DEPTH = deq_pkg::DEPTH_DEFAULT;
  localparam int ITEMS = 310;
  // kinds above remove are ignored by the block
  localparam logic [deq_pkg::KIND_W-1:0] KIND_UNUSED_LO = deq_pkg::KIND_REMOVE + 3'd1;
  localparam logic [deq_pkg::KIND_W-1:0] KIND_UNUSED_HI = '1;
  localparam logic signed [deq_pkg::DATA_W-1:0] VAL_MAX =
    {1'b0, {(deq_pkg::DATA_W-1){1'b1}}};
  localparam logic signed [deq_pkg::DATA_W-1:0] VAL_MIN =
    {1'b1, {(deq_pkg::DATA_W-1){1'b0}}};

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  deq_pkg::in_req_t  in_req;
  logic              out_valid;
  deq_pkg::out_res_t out_res;
  int                mismatches;
  int                outstanding;

  int       issued;    // requests that give at least one result
  bit       gaps_on;   // allow random sender gaps

  deque_with_remove_all_max #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  deq_result_checker #(.DEPTH(DEPTH)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_res        (out_res),
    .mismatch_count (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Half the time a small pool of values so that equal maxima are common; the rest
  // are the extremes or fully random words so every bit toggles.
  function automatic logic signed [deq_pkg::DATA_W-1:0] pick_value();
    logic signed [deq_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = int'($urandom_range(0, 7)) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [deq_pkg::KIND_W-1:0] any_push();
    return ($urandom_range(0, 1) != 0) ? deq_pkg::KIND_PUSH_TAIL : deq_pkg::KIND_PUSH_HEAD;
  endfunction

  // Present one request at the falling edge and hold it until the block
  // takes it (start high, busy low at a rising edge). Occasionally drop
  // start for a random burst first, with junk on the request bus.
  task automatic send_request(logic [deq_pkg::KIND_W-1:0] kind,
                              logic signed [deq_pkg::DATA_W-1:0] value);
    deq_pkg::in_req_t req;
    deq_pkg::in_req_t junk;
    int               gap;
    req.kind  = kind;
    req.value = value;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      repeat (gap) begin
        @(negedge clk);
        junk.kind  = deq_pkg::KIND_W'($urandom);
        junk.value = $urandom;
        start  <= 1'b0;
        in_req <= junk;
      end
    end
    @(negedge clk);
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    if (kind <= deq_pkg::KIND_REMOVE) issued++;
  endtask

  initial begin
    int roll;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_req  = '0;
    issued  = 0;
    gaps_on = 1'b1;

    // hold reset, then release on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty store on every read kind, the ignored kinds, extremes,
    // duplicate maxima, a maximum away from the head, and removal down to empty.
    send_request(deq_pkg::KIND_READ_HEAD, '0);
    send_request(deq_pkg::KIND_READ_TAIL, '1);
    send_request(deq_pkg::KIND_REMOVE, VAL_MAX);
    send_request(KIND_UNUSED_LO, VAL_MIN);
    send_request(KIND_UNUSED_LO + 3'd1, '1);
    send_request(KIND_UNUSED_HI, '0);
    send_request(deq_pkg::KIND_PUSH_HEAD, VAL_MAX);
    send_request(deq_pkg::KIND_PUSH_TAIL, VAL_MIN);
    send_request(deq_pkg::KIND_PUSH_HEAD, '1);
    send_request(deq_pkg::KIND_PUSH_TAIL, '0);
    send_request(deq_pkg::KIND_PUSH_TAIL, VAL_MAX);
    send_request(deq_pkg::KIND_PUSH_HEAD, 32'sh5555_5555);
    send_request(deq_pkg::KIND_PUSH_TAIL, 32'shAAAA_AAAA);
    send_request(deq_pkg::KIND_READ_HEAD, '0);
    send_request(deq_pkg::KIND_READ_TAIL, '0);
    send_request(deq_pkg::KIND_REMOVE, '0);      // both copies of the largest value
    send_request(deq_pkg::KIND_REMOVE, '0);
    send_request(deq_pkg::KIND_READ_HEAD, '0);
    send_request(deq_pkg::KIND_PUSH_HEAD, '1);
    send_request(deq_pkg::KIND_REMOVE, '0);
    send_request(deq_pkg::KIND_REMOVE, '0);      // two equal negative entries
    send_request(deq_pkg::KIND_REMOVE, '0);      // the larger of the last two entries goes, the minimum stays
    send_request(deq_pkg::KIND_REMOVE, '0);
    send_request(deq_pkg::KIND_PUSH_TAIL, 32'sd5);
    send_request(deq_pkg::KIND_READ_TAIL, '0);
    send_request(deq_pkg::KIND_REMOVE, '0);      // single entry

    // Fill past capacity so the full case and full read-outs are seen early.
    repeat (DEPTH + 2) send_request(any_push(), pick_value());
    send_request(deq_pkg::KIND_READ_HEAD, '0);
    send_request(deq_pkg::KIND_READ_TAIL, '0);
    send_request(deq_pkg::KIND_REMOVE, '0);

    // Random mix; the tail end runs without gaps.
    while (issued < ITEMS) begin
      gaps_on = (issued < ITEMS - 40);
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        send_request(any_push(), pick_value());
      end else if (roll < 60) begin
        send_request(($urandom_range(0, 1) != 0) ? deq_pkg::KIND_READ_TAIL :
                     deq_pkg::KIND_READ_HEAD, $urandom);
      end else if (roll < 76) begin
        send_request(deq_pkg::KIND_REMOVE, $urandom);
      end else if (roll < 79) begin
        send_request(KIND_UNUSED_LO + 3'($urandom_range(0, 2)), $urandom);
      end else if (roll < 81) begin
        repeat (DEPTH + 2) send_request(any_push(), pick_value());
      end else begin
        repeat ($urandom_range(2, 6)) send_request(any_push(), pick_value());
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // drain, then allow a full removal pass for any stray result
    wait (outstanding == 0);
    repeat (2 * DEPTH + 8) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
src/deq_pkg.sv
src/deq_cell.sv
src/deque_with_remove_all_max.sv
tb/deq_result_checker.sv
tb/tb_deque_with_remove_all_max.sv
